// ===== design/mbrd_pkg.sv =====
// Shared types, codes and the CRC-16 step for the Modbus read-register master.
package mbrd_pkg;

	localparam int CMDQ_DEPTH = 4;
	localparam int CMDQ_AW = $clog2(CMDQ_DEPTH);

	localparam logic [0:0] REG_SLAVE_ADDR = 1'b0;
	localparam logic [0:0] REG_TIMEOUT = 1'b1;

	localparam logic [7:0] FUNC_READ_HOLDING = 8'h03;
	localparam logic [7:0] REPLY_BYTE_COUNT = 8'h02;
	localparam logic [15:0] CRC_POLY = 16'hA001;
	localparam logic [15:0] CRC_PRESET = 16'hFFFF;
	localparam logic [2:0] RX_FRAME_LAST = 3'd6;
	localparam logic [2:0] RX_CRC_START = 3'd5;

	typedef enum logic [1:0] {
		REQ_START = 2'd0,
		REQ_BYTE = 2'd1,
		REQ_TICK = 2'd2
	} req_type_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_TIMEOUT = 2'd1,
		ST_HEADER = 2'd2,
		ST_CRC = 2'd3
	} status_t;

	typedef enum logic {
		CMD_START = 1'b0,
		CMD_REPORT = 1'b1
	} cmd_kind_t;

	typedef enum logic {
		RES_TX = 1'b0,
		RES_REPORT = 1'b1
	} res_kind_t;

	typedef struct packed {
		cmd_kind_t kind;
		logic [7:0] slave_addr;
		logic [15:0] reg_addr;
		status_t status;
		logic [15:0] value;
	} cmd_t;

	function automatic logic [15:0] crc_feed(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			if (r[0]) begin
				r = (r >> 1) ^ CRC_POLY;
			end else begin
				r = r >> 1;
			end
		end
		return r;
	endfunction

endpackage

// ===== design/mbrd_front.sv =====
// Front end: takes items, tracks the reply, queues start and report commands.
module mbrd_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  logic                full,
	input  logic [1:0]          req_type,
	input  logic [15:0]         reg_addr,
	input  logic [7:0]          rx_byte,
	input  logic [7:0]          slave_address,
	input  logic [15:0]         timeout_ticks,
	output logic                cmd_push,
	output mbrd_pkg::cmd_t      cmd
);

	logic        phase_q;
	logic [7:0]  rx_buf_q [7];
	logic [2:0]  rx_count_q;
	logic [15:0] crc_q;
	logic [15:0] ticks_q;

	logic        take;
	logic        is_start, is_byte, is_tick;
	logic        frame_done, timed_out;
	logic        hdr_bad, crc_bad;
	logic [15:0] ticks_next;

	assign take = push && !full;
	assign is_start = take && (req_type == mbrd_pkg::REQ_START) && !phase_q;
	assign is_byte = take && (req_type == mbrd_pkg::REQ_BYTE) && phase_q;
	assign is_tick = take && (req_type == mbrd_pkg::REQ_TICK) && phase_q
		&& (timeout_ticks != 16'd0);

	assign ticks_next = (ticks_q == 16'hFFFF) ? ticks_q : ticks_q + 16'd1;
	assign frame_done = is_byte && (rx_count_q == mbrd_pkg::RX_FRAME_LAST);
	assign timed_out = is_tick && (ticks_next >= timeout_ticks);

	assign hdr_bad = (rx_buf_q[0] != slave_address)
		|| (rx_buf_q[1] != mbrd_pkg::FUNC_READ_HOLDING)
		|| (rx_buf_q[2] != mbrd_pkg::REPLY_BYTE_COUNT);
	assign crc_bad = ({rx_byte, rx_buf_q[5]} != crc_q);

	always_comb begin
		cmd_push = is_start || frame_done || timed_out;
		cmd.kind = is_start ? mbrd_pkg::CMD_START : mbrd_pkg::CMD_REPORT;
		cmd.slave_addr = slave_address;
		cmd.reg_addr = reg_addr;
		cmd.status = mbrd_pkg::ST_OK;
		cmd.value = 16'd0;
		if (timed_out) begin
			cmd.status = mbrd_pkg::ST_TIMEOUT;
		end else if (hdr_bad) begin
			cmd.status = mbrd_pkg::ST_HEADER;
		end else if (crc_bad) begin
			cmd.status = mbrd_pkg::ST_CRC;
		end else begin
			cmd.value = {rx_buf_q[3], rx_buf_q[4]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= 1'b0;
			rx_count_q <= 3'd0;
			crc_q <= mbrd_pkg::CRC_PRESET;
			ticks_q <= 16'd0;
		end else begin
			if (is_start) begin
				phase_q <= 1'b1;
				rx_count_q <= 3'd0;
				crc_q <= mbrd_pkg::CRC_PRESET;
				ticks_q <= 16'd0;
			end else if (is_byte) begin
				if (rx_count_q < mbrd_pkg::RX_CRC_START) begin
					crc_q <= mbrd_pkg::crc_feed(crc_q, rx_byte);
				end
				rx_count_q <= rx_count_q + 3'd1;
				ticks_q <= 16'd0;
				if (frame_done) begin
					phase_q <= 1'b0;
				end
			end else if (is_tick) begin
				ticks_q <= ticks_next;
				if (timed_out) begin
					phase_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (is_byte) begin
			rx_buf_q[rx_count_q] <= rx_byte;
		end
	end

endmodule

// ===== design/mbrd_cmd_fifo.sv =====
// Short command queue between the front end and the frame engine.
module mbrd_cmd_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  mbrd_pkg::cmd_t      wr_data,
	input  logic                rd_en,
	output mbrd_pkg::cmd_t      rd_data,
	output logic                q_full,
	output logic                q_empty
);

	mbrd_pkg::cmd_t mem_q [mbrd_pkg::CMDQ_DEPTH];
	logic [mbrd_pkg::CMDQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [mbrd_pkg::CMDQ_AW:0] count_q;
	logic do_wr, do_rd;

	assign q_full = (count_q == (mbrd_pkg::CMDQ_AW + 1)'(mbrd_pkg::CMDQ_DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr = wr_en && !q_full;
	assign do_rd = rd_en && !q_empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mbrd_back.sv =====
// Frame engine: expands start commands into the request frame, passes reports.
module mbrd_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mbrd_pkg::cmd_t      head,
	input  logic                q_empty,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output logic                result_kind,
	output logic [7:0]          tx_byte,
	output logic                tx_last,
	output logic [1:0]          status,
	output logic [15:0]         reg_value
);

	logic        busy_q;
	logic [2:0]  idx_q;
	logic [15:0] crc_q;
	logic [7:0]  addr_q;
	logic [15:0] reg_q;

	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [1:0]  status_q;
	logic [15:0] value_q;

	logic        out_free, load;
	logic [7:0]  cur_byte;

	assign out_free = !out_valid_q || pop;
	assign load = out_free && (busy_q || !q_empty);
	assign q_pop = out_free && !busy_q && !q_empty;

	always_comb begin
		case (idx_q)
			3'd1: cur_byte = mbrd_pkg::FUNC_READ_HOLDING;
			3'd2: cur_byte = reg_q[15:8];
			3'd3: cur_byte = reg_q[7:0];
			3'd4: cur_byte = 8'h00;
			3'd5: cur_byte = 8'h01;
			3'd6: cur_byte = crc_q[7:0];
			3'd7: cur_byte = crc_q[15:8];
			default: cur_byte = addr_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
			if (load && busy_q) begin
				idx_q <= idx_q + 3'd1;
				if (idx_q == 3'd7) begin
					busy_q <= 1'b0;
				end
			end else if (q_pop && head.kind == mbrd_pkg::CMD_START) begin
				busy_q <= 1'b1;
				idx_q <= 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && busy_q) begin
			if (idx_q < 3'd6) begin
				crc_q <= mbrd_pkg::crc_feed(crc_q, cur_byte);
			end
			kind_q <= mbrd_pkg::RES_TX;
			byte_q <= cur_byte;
			last_q <= (idx_q == 3'd7);
			status_q <= mbrd_pkg::ST_OK;
			value_q <= 16'd0;
		end else if (q_pop) begin
			if (head.kind == mbrd_pkg::CMD_START) begin
				addr_q <= head.slave_addr;
				reg_q <= head.reg_addr;
				crc_q <= mbrd_pkg::crc_feed(mbrd_pkg::CRC_PRESET, head.slave_addr);
				kind_q <= mbrd_pkg::RES_TX;
				byte_q <= head.slave_addr;
				last_q <= 1'b0;
				status_q <= mbrd_pkg::ST_OK;
				value_q <= 16'd0;
			end else begin
				kind_q <= mbrd_pkg::RES_REPORT;
				byte_q <= 8'h00;
				last_q <= 1'b0;
				status_q <= head.status;
				value_q <= head.value;
			end
		end
	end

	assign empty = !out_valid_q;
	assign result_kind = kind_q;
	assign tx_byte = byte_q;
	assign tx_last = last_q;
	assign status = status_q;
	assign reg_value = value_q;

	a_no_pop_busy: assert property (@(posedge clk) disable iff (!arst_n)
		q_pop |-> !busy_q)
		else $error("command popped while frame in progress");

	a_idx_step: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q && idx_q != 3'd7) |=> busy_q && idx_q == $past(idx_q) + 3'd1)
		else $error("frame index did not advance");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(load && busy_q && idx_q == 3'd7) |=> !busy_q && out_valid_q && last_q)
		else $error("last frame byte did not end the frame");

endmodule

// ===== design/modbus_rtu_read_register_master_unit.sv =====
// Top level of the Modbus RTU read-holding-register master.
// Usage:
//   Input queue (push/full): req_type 0 starts a read of reg_addr, 1 hands in a
//   received bus byte in rx_byte, 2 is a one-millisecond tick. Start is ignored
//   while a reply is awaited; bytes and ticks are ignored while idle.
//   Result queue (empty/pop): result_kind 0 carries one request byte in tx_byte,
//   tx_last marks the eighth; result_kind 1 is the report with status and
//   reg_value. Configuration: cfg_we, cfg_index (0 slave address, 1 timeout in
//   ticks, 0 waits forever), cfg_data; write only while idle.
// Timing:
//   An item is taken every cycle while full is low. A start or the final reply
//   byte or the timing-out tick is written to the command queue as it is taken;
//   the frame engine registers its first result from the queue head once its
//   output register is free. A start yields eight bytes, one per cycle while pop
//   keeps the output free, from the frame engine, which computes the CRC one byte
//   a cycle. A four-entry command queue sits between front end and frame engine,
//   so input keeps flowing while results wait; full rises only when it fills.
// Reset: slave address 1, timeout 500, idle, both queues empty.
// A stalled pop holds the current result and lets the queue fill.
module modbus_rtu_read_register_master_unit (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	output logic         full,
	input  logic [1:0]   req_type,
	input  logic [15:0]  reg_addr,
	input  logic [7:0]   rx_byte,
	output logic         empty,
	input  logic         pop,
	output logic         result_kind,
	output logic [7:0]   tx_byte,
	output logic         tx_last,
	output logic [1:0]   status,
	output logic [15:0]  reg_value,
	input  logic         cfg_we,
	input  logic [0:0]   cfg_index,
	input  logic [15:0]  cfg_data
);

	logic [7:0]  slave_addr_q;
	logic [15:0] timeout_q;

	logic           cmd_push, q_pop, q_empty;
	mbrd_pkg::cmd_t cmd, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slave_addr_q <= 8'd1;
			timeout_q <= 16'd500;
		end else if (cfg_we) begin
			case (cfg_index)
				mbrd_pkg::REG_SLAVE_ADDR: slave_addr_q <= cfg_data[7:0];
				mbrd_pkg::REG_TIMEOUT: timeout_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mbrd_front u_front (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.reg_addr(reg_addr),
		.rx_byte(rx_byte),
		.slave_address(slave_addr_q),
		.timeout_ticks(timeout_q),
		.cmd_push(cmd_push),
		.cmd(cmd)
	);

	mbrd_cmd_fifo u_cmdq (
		.clk(clk),
		.arst_n(arst_n),
		.wr_en(cmd_push),
		.wr_data(cmd),
		.rd_en(q_pop),
		.rd_data(head),
		.q_full(full),
		.q_empty(q_empty)
	);

	mbrd_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.q_empty(q_empty),
		.q_pop(q_pop),
		.pop(pop),
		.empty(empty),
		.result_kind(result_kind),
		.tx_byte(tx_byte),
		.tx_last(tx_last),
		.status(status),
		.reg_value(reg_value)
	);

endmodule

// ===== bench/modbus_rtu_read_register_master_unit_test.sv =====
// Self-checking bench for the Modbus RTU read-register master: frames, replies, timeouts.
`timescale 1ns / 100ps

module modbus_rtu_read_register_master_unit_test;

	localparam logic [1:0] REQ_UNUSED = 2'd3;
	localparam int RX_LEN = 7;
	localparam int QUIET_LIMIT = 3000;

	typedef struct {
		mbrd_pkg::res_kind_t kind;
		logic [7:0] txb;
		logic last;
		mbrd_pkg::status_t st;
		logic [15:0] val;
	} mb_result_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [1:0] req_type = mbrd_pkg::REQ_START;
	logic [15:0] reg_addr = '0;
	logic [7:0] rx_byte = '0;
	logic empty;
	logic pop = 1'b0;
	logic result_kind;
	logic [7:0] tx_byte;
	logic tx_last;
	logic [1:0] status;
	logic [15:0] reg_value;
	logic cfg_we = 1'b0;
	logic [0:0] cfg_index = mbrd_pkg::REG_SLAVE_ADDR;
	logic [15:0] cfg_data = '0;

	// bus master shadow state
	logic [7:0] cfg_slave = 8'd1;
	logic [15:0] cfg_ticks = 16'd500;
	logic awaiting = 1'b0;
	logic [7:0] rx_buf [RX_LEN];
	int rx_n = 0;
	logic [15:0] rx_crc = mbrd_pkg::CRC_PRESET;
	logic [15:0] silent = '0;

	mb_result_t frame_and_report_q [$];
	mb_result_t head;
	int served_items = 0;
	int fail_count = 0;
	bit no_gaps = 1'b0;
	bit hold_pop = 1'b0;

	modbus_rtu_read_register_master_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.full(full),
		.req_type(req_type),
		.reg_addr(reg_addr),
		.rx_byte(rx_byte),
		.empty(empty),
		.pop(pop),
		.result_kind(result_kind),
		.tx_byte(tx_byte),
		.tx_last(tx_last),
		.status(status),
		.reg_value(reg_value),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic logic [15:0] crc16_modbus(input logic [15:0] acc, input logic [7:0] data);
		logic [15:0] v;
		v = acc ^ {8'h00, data};
		repeat (8) begin
			v = v[0] ? ({1'b0, v[15:1]} ^ mbrd_pkg::CRC_POLY) : {1'b0, v[15:1]};
		end
		return v;
	endfunction

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) begin
			return 0;
		end
		if (r < 90) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(8, 40);
	endfunction

	task automatic add_tx(input logic [7:0] b, input logic last);
		mb_result_t r;
		r.kind = mbrd_pkg::RES_TX;
		r.txb = b;
		r.last = last;
		r.st = mbrd_pkg::ST_OK;
		r.val = '0;
		frame_and_report_q.push_back(r);
	endtask

	task automatic add_report(input mbrd_pkg::status_t st, input logic [15:0] v);
		mb_result_t r;
		r.kind = mbrd_pkg::RES_REPORT;
		r.txb = '0;
		r.last = 1'b0;
		r.st = st;
		r.val = v;
		frame_and_report_q.push_back(r);
	endtask

	// advance the shadow master by one accepted item
	task automatic advance_master(input logic [1:0] kind, input logic [15:0] ra,
			input logic [7:0] rb);
		logic [7:0] frame [6];
		logic [15:0] c;
		case (kind)
			mbrd_pkg::REQ_START: begin
				if (!awaiting) begin
					frame[0] = cfg_slave;
					frame[1] = mbrd_pkg::FUNC_READ_HOLDING;
					frame[2] = ra[15:8];
					frame[3] = ra[7:0];
					frame[4] = 8'h00;
					frame[5] = 8'h01;
					c = mbrd_pkg::CRC_PRESET;
					for (int i = 0; i < 6; i++) begin
						add_tx(frame[i], 1'b0);
						c = crc16_modbus(c, frame[i]);
					end
					add_tx(c[7:0], 1'b0);
					add_tx(c[15:8], 1'b1);
					awaiting = 1'b1;
					rx_n = 0;
					silent = '0;
					rx_crc = mbrd_pkg::CRC_PRESET;
					served_items++;
				end
			end
			mbrd_pkg::REQ_BYTE: begin
				if (awaiting) begin
					served_items++;
					if (rx_n < RX_LEN) begin
						rx_buf[rx_n] = rb;
						if (rx_n < RX_LEN - 2) begin
							rx_crc = crc16_modbus(rx_crc, rb);
						end
						rx_n++;
					end
					silent = '0;
					if (rx_n == RX_LEN) begin
						awaiting = 1'b0;
						if (rx_buf[0] != cfg_slave || rx_buf[1] != mbrd_pkg::FUNC_READ_HOLDING ||
								rx_buf[2] != mbrd_pkg::REPLY_BYTE_COUNT) begin
							add_report(mbrd_pkg::ST_HEADER, '0);
						end else if ({rx_buf[6], rx_buf[5]} != rx_crc) begin
							add_report(mbrd_pkg::ST_CRC, '0);
						end else begin
							add_report(mbrd_pkg::ST_OK, {rx_buf[3], rx_buf[4]});
						end
					end
				end
			end
			mbrd_pkg::REQ_TICK: begin
				if (awaiting && cfg_ticks != 0) begin
					served_items++;
					if (silent != 16'hFFFF) begin
						silent++;
					end
					if (silent >= cfg_ticks) begin
						awaiting = 1'b0;
						add_report(mbrd_pkg::ST_TIMEOUT, '0);
					end
				end
			end
			default: ;
		endcase
	endtask

	task automatic send_item(input logic [1:0] kind, input logic [15:0] ra, input logic [7:0] rb);
		int gap;
		@(negedge clk);
		push <= 1'b1;
		req_type <= kind;
		reg_addr <= ra;
		rx_byte <= rb;
		@(posedge clk);
		while (full) @(posedge clk);
		advance_master(kind, ra, rb);
		gap = pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			push <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// sender pause: everything expected has come and the pipeline is quiet
	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (frame_and_report_q.size() != 0) @(posedge clk);
		repeat (16) @(posedge clk);
	endtask

	task automatic write_reg(input logic [0:0] idx, input logic [15:0] data);
		settle();
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == mbrd_pkg::REG_SLAVE_ADDR) begin
			cfg_slave = data[7:0];
		end else begin
			cfg_ticks = data;
		end
	endtask

	task automatic send_reply(input logic [7:0] addr, input logic [7:0] func, input logic [7:0] cnt,
			input logic [15:0] value, input logic [15:0] crc_flip, input bit spaced);
		logic [7:0] b [RX_LEN];
		logic [15:0] c;
		int n;
		b[0] = addr;
		b[1] = func;
		b[2] = cnt;
		b[3] = value[15:8];
		b[4] = value[7:0];
		c = mbrd_pkg::CRC_PRESET;
		for (int i = 0; i < 5; i++) begin
			c = crc16_modbus(c, b[i]);
		end
		c ^= crc_flip;
		b[5] = c[7:0];
		b[6] = c[15:8];
		for (int i = 0; i < RX_LEN; i++) begin
			n = spaced ? $urandom_range(0, 2) : 0;
			while (n > 0 && (cfg_ticks == 0 || silent + 1 < cfg_ticks)) begin
				send_item(mbrd_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
				n--;
			end
			send_item(mbrd_pkg::REQ_BYTE, 16'($urandom), b[i]);
		end
	endtask

	task automatic test_ignored_items();
		send_item(mbrd_pkg::REQ_BYTE, 16'h0000, 8'hFF);
		send_item(mbrd_pkg::REQ_TICK, 16'hFFFF, 8'h00);
		send_item(REQ_UNUSED, 16'hA5A5, 8'h5A);
		send_item(mbrd_pkg::REQ_START, 16'hFFFF, 8'h00);
		send_item(mbrd_pkg::REQ_START, 16'h0000, 8'hFF);
		send_item(REQ_UNUSED, 16'h5A5A, 8'hA5);
		send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, 16'hFFFF,
			'0, 1'b0);
	endtask

	task automatic test_header_and_crc_wrong();
		send_item(mbrd_pkg::REQ_START, 16'h0000, 8'($urandom));
		send_reply(cfg_slave ^ 8'h80, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT,
			16'h0000, 16'h0101, 1'b0);
	endtask

	task automatic test_timeout_after_bytes();
		write_reg(mbrd_pkg::REG_TIMEOUT, 16'd2);
		send_item(mbrd_pkg::REQ_START, 16'($urandom), 8'($urandom));
		repeat (3) send_item(mbrd_pkg::REQ_BYTE, 16'($urandom), 8'($urandom));
		repeat (2) send_item(mbrd_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
	endtask

	task automatic test_config_extremes();
		write_reg(mbrd_pkg::REG_SLAVE_ADDR, 16'hFF00);
		write_reg(mbrd_pkg::REG_TIMEOUT, 16'h0000);
		send_item(mbrd_pkg::REQ_START, 16'h0000, 8'($urandom));
		repeat (4) send_item(mbrd_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
		send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, 16'hFFFF,
			'0, 1'b1);
		write_reg(mbrd_pkg::REG_SLAVE_ADDR, 16'h00FF);
		write_reg(mbrd_pkg::REG_TIMEOUT, 16'hFFFF);
		send_item(mbrd_pkg::REQ_START, 16'hFFFF, 8'($urandom));
		send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, 16'h0000,
			'0, 1'b1);
	endtask

	// stall the result side until the command queue backs up into full
	task automatic test_backpressure();
		write_reg(mbrd_pkg::REG_TIMEOUT, 16'd1);
		hold_pop = 1'b1;
		fork
			begin
				repeat (6) begin
					send_item(mbrd_pkg::REQ_START, 16'($urandom), 8'($urandom));
					send_item(mbrd_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
				end
			end
			begin
				repeat (300) begin
					@(posedge clk);
					if (full) break;
				end
				hold_pop = 1'b0;
			end
		join
		settle();
	endtask

	task automatic test_random_reads();
		int pick;
		logic [15:0] val;
		while (served_items < 80) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 3) == 0) begin
				case ($urandom_range(0, 3))
					0: write_reg(mbrd_pkg::REG_SLAVE_ADDR, {8'($urandom), 8'h00});
					1: write_reg(mbrd_pkg::REG_SLAVE_ADDR, {8'($urandom), 8'hFF});
					default: write_reg(mbrd_pkg::REG_SLAVE_ADDR, 16'($urandom));
				endcase
				case ($urandom_range(0, 5))
					0: write_reg(mbrd_pkg::REG_TIMEOUT, 16'd0);
					1: write_reg(mbrd_pkg::REG_TIMEOUT, 16'd1);
					2: write_reg(mbrd_pkg::REG_TIMEOUT, 16'd2);
					3: write_reg(mbrd_pkg::REG_TIMEOUT, 16'($urandom_range(3, 16)));
					4: write_reg(mbrd_pkg::REG_TIMEOUT, 16'd500);
					default: write_reg(mbrd_pkg::REG_TIMEOUT, 16'($urandom_range(17, 65535)));
				endcase
			end
			if ($urandom_range(0, 4) == 0) begin
				send_item(2'($urandom_range(mbrd_pkg::REQ_BYTE, REQ_UNUSED)), 16'($urandom),
					8'($urandom));
			end
			send_item(mbrd_pkg::REQ_START, 16'($urandom), 8'($urandom));
			pick = $urandom_range(0, 99);
			val = 16'($urandom);
			if (pick < 52) begin
				send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, val,
					'0, 1'b1);
			end else if (pick < 59) begin
				send_reply(cfg_slave ^ 8'($urandom_range(1, 255)), mbrd_pkg::FUNC_READ_HOLDING,
					mbrd_pkg::REPLY_BYTE_COUNT, val, '0, 1'b1);
			end else if (pick < 65) begin
				send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING ^ 8'($urandom_range(1, 255)),
					mbrd_pkg::REPLY_BYTE_COUNT, val, '0, 1'b1);
			end else if (pick < 71) begin
				send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING,
					mbrd_pkg::REPLY_BYTE_COUNT ^ 8'($urandom_range(1, 255)), val, '0, 1'b1);
			end else if (pick < 81) begin
				send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, val,
					16'($urandom_range(1, 65535)), 1'b1);
			end else if (pick < 85) begin
				send_reply(8'($urandom), 8'($urandom), 8'($urandom), val, 16'($urandom), 1'b1);
			end else if (pick < 94 && cfg_ticks != 0 && cfg_ticks <= 16) begin
				repeat ($urandom_range(0, 6))
					send_item(mbrd_pkg::REQ_BYTE, 16'($urandom), 8'($urandom));
				while (awaiting) send_item(mbrd_pkg::REQ_TICK, 16'($urandom), 8'($urandom));
			end else begin
				send_item(mbrd_pkg::REQ_START, 16'($urandom), 8'($urandom));
				send_item(REQ_UNUSED, 16'($urandom), 8'($urandom));
				send_reply(cfg_slave, mbrd_pkg::FUNC_READ_HOLDING, mbrd_pkg::REPLY_BYTE_COUNT, val,
					'0, 1'b1);
			end
			if ($urandom_range(0, 5) == 0) begin
				send_item(mbrd_pkg::REQ_BYTE, 16'($urandom), 8'($urandom));
			end
		end
		no_gaps = 1'b0;
	endtask

	task automatic check_field(input string what, input logic [15:0] want, input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (frame_and_report_q.size() == 0) begin
				$display("%0t: unexpected item, kind %h byte %h status %h value %h", $time,
					result_kind, tx_byte, status, reg_value);
				fail_count++;
			end else begin
				head = frame_and_report_q.pop_front();
				check_field("result_kind", 16'(head.kind), 16'(result_kind));
				check_field("tx_byte", 16'(head.txb), 16'(tx_byte));
				check_field("tx_last", 16'(head.last), 16'(tx_last));
				check_field("status", 16'(head.st), 16'(status));
				check_field("reg_value", head.val, reg_value);
			end
		end
	end

	initial begin
		int run;
		int gap;
		forever begin
			run = $urandom_range(1, 24);
			repeat (run) begin
				@(negedge clk);
				pop <= !hold_pop;
			end
			gap = pick_gap();
			repeat (gap) begin
				@(negedge clk);
				pop <= 1'b0;
			end
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (push && !full) || (pop && !empty)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no item moved for %0d cycles", $time, QUIET_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_ignored_items();
		test_header_and_crc_wrong();
		test_timeout_after_bytes();
		test_config_extremes();
		test_backpressure();
		test_random_reads();
		settle();
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

// ===== files.f =====
design/mbrd_pkg.sv
design/mbrd_front.sv
design/mbrd_cmd_fifo.sv
design/mbrd_back.sv
design/modbus_rtu_read_register_master_unit.sv
bench/modbus_rtu_read_register_master_unit_test.sv
